[hdl/stq_pkg.sv]
`timescale 1ns / 1ps
package stq_pkg;

  localparam int NumTimers = 16;
  localparam int TickWidth = 32;
  localparam int IdWidth   = 4;
  localparam int FuncWidth = 2;

  typedef enum logic [FuncWidth-1:0] {
    FUNC_START = 2'd0,
    FUNC_STOP  = 2'd1,
    FUNC_CHECK = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CELL_NOP    = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_POP    = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic                 valid;
    logic [IdWidth-1:0]   id;
    logic [TickWidth-1:0] expiry;
  } slot_t;

  typedef struct packed {
    cell_op_e             op;
    logic [IdWidth-1:0]   id;
    logic [TickWidth-1:0] expiry;
  } cell_cmd_t;

  // a strictly before b, wrap-aware
  function automatic logic tick_before(logic [TickWidth-1:0] a, logic [TickWidth-1:0] b);
    logic [TickWidth-1:0] d;
    d = a - b;
    return d[TickWidth-1];
  endfunction

  // a strictly after b, wrap-aware
  function automatic logic tick_after(logic [TickWidth-1:0] a, logic [TickWidth-1:0] b);
    logic [TickWidth-1:0] d;
    d = a - b;
    return (d != '0) && !d[TickWidth-1];
  endfunction

endpackage

[hdl/sorted_timer_expiry_queue.sv]
`timescale 1ns / 1ps
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_stall_o | func_i timer_id_i expiry_tick_i now_tick_i
// out     | output    | out_valid_o/out_stall_i | kind_o expired_id_o compare_enable_o
//         |           |                         | compare_value_o error_o last_o
// Start and stop update the row of cells in the accept cycle; status is loaded in S_STATUS.
// Unless stalled, a check pops one expired head per cycle, one notice each, then status.
// The longest item is a check that pops all NumTimers queued heads before its status.
// Reset empties the queue at once; no clearing pass. out_stall_i holds the result
// register and pauses popping; in_stall_o stays high until the status item is loaded.
module sorted_timer_expiry_queue (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [stq_pkg::FuncWidth-1:0]       func_i,
  input  logic [stq_pkg::IdWidth-1:0]         timer_id_i,
  input  logic [stq_pkg::TickWidth-1:0]       expiry_tick_i,
  input  logic [stq_pkg::TickWidth-1:0]       now_tick_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                kind_o,
  output logic [stq_pkg::IdWidth-1:0]         expired_id_o,
  output logic                                compare_enable_o,
  output logic [stq_pkg::TickWidth-1:0]       compare_value_o,
  output logic                                error_o,
  output logic                                last_o
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_CHECK  = 3'b010,
    S_STATUS = 3'b100
  } state_e;

  state_e                          state_q, state_d;
  logic [stq_pkg::NumTimers-1:0]   running_q, running_d;
  logic [stq_pkg::TickWidth-1:0]   now_q;
  logic                            err_q, err_d;
  logic                            out_valid_q;
  logic                            kind_q, en_q, errout_q, last_q;
  logic [stq_pkg::IdWidth-1:0]     id_q;
  logic [stq_pkg::TickWidth-1:0]   val_q;

  stq_pkg::cell_cmd_t              cmd;
  stq_pkg::slot_t                  slots [stq_pkg::NumTimers];
  logic [stq_pkg::NumTimers:0]     hit;
  logic [stq_pkg::NumTimers-1:0]   valid_vec;
  stq_pkg::slot_t                  head;
  stq_pkg::slot_t                  edge_slot;
  stq_pkg::slot_t                  empty_slot;
  logic                            in_acc, out_free, load_notice, load_status;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign head       = slots[0];

  // neighbor ties at the two ends of the row
  always_comb begin
    edge_slot        = '0;
    edge_slot.valid  = 1'b1;
    empty_slot       = '0;
  end

  assign hit[0] = 1'b0;

  for (genvar g = 0; g < stq_pkg::NumTimers; g++) begin : g_cell
    stq_pkg::slot_t left_s, right_s;
    if (g == 0) begin : g_first
      assign left_s = edge_slot;
    end else begin : g_mid
      assign left_s = slots[g-1];
    end
    if (g == stq_pkg::NumTimers - 1) begin : g_last
      assign right_s = empty_slot;
    end else begin : g_inner
      assign right_s = slots[g+1];
    end
    stq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .left_i (left_s),
      .right_i(right_s),
      .hit_i  (hit[g]),
      .hit_o  (hit[g+1]),
      .slot_o (slots[g])
    );
    assign valid_vec[g] = slots[g].valid;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    running_d   = running_q;
    err_d       = err_q;
    cmd.op      = stq_pkg::CELL_NOP;
    cmd.id      = timer_id_i;
    cmd.expiry  = expiry_tick_i;
    load_notice = 1'b0;
    load_status = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          err_d   = 1'b0;
          state_d = S_STATUS;
          case (stq_pkg::func_e'(func_i))
            stq_pkg::FUNC_START: begin
              if (running_q[timer_id_i] || valid_vec[stq_pkg::NumTimers-1]) begin
                err_d = 1'b1;
              end else begin
                cmd.op                 = stq_pkg::CELL_INSERT;
                running_d[timer_id_i]  = 1'b1;
              end
            end
            stq_pkg::FUNC_STOP: begin
              if (running_q[timer_id_i]) begin
                cmd.op                 = stq_pkg::CELL_REMOVE;
                running_d[timer_id_i]  = 1'b0;
              end
            end
            stq_pkg::FUNC_CHECK: state_d = S_CHECK;
            default: state_d = S_STATUS;
          endcase
        end
      end
      S_CHECK: begin
        if (out_free) begin
          if (head.valid && !stq_pkg::tick_after(head.expiry, now_q)) begin
            cmd.op               = stq_pkg::CELL_POP;
            running_d[head.id]   = 1'b0;
            load_notice          = 1'b1;
          end else begin
            state_d = S_STATUS;
          end
        end
      end
      S_STATUS: begin
        if (out_free) begin
          load_status = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      running_q   <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      running_q <= running_d;
      err_q     <= err_d;
      if (load_notice || load_status) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) now_q <= now_tick_i;
    if (load_notice) begin
      kind_q   <= 1'b0;
      id_q     <= head.id;
      en_q     <= 1'b0;
      val_q    <= '0;
      errout_q <= 1'b0;
      last_q   <= 1'b0;
    end else if (load_status) begin
      kind_q   <= 1'b1;
      id_q     <= '0;
      en_q     <= head.valid;
      val_q    <= head.valid ? head.expiry : '0;
      errout_q <= err_q;
      last_q   <= 1'b1;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign expired_id_o     = id_q;
  assign compare_enable_o = en_q;
  assign compare_value_o  = val_q;
  assign error_o          = errout_q;
  assign last_o           = last_q;

  // checks
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kind_o == last_o))
    else $error("status item and last flag disagree");

  a_notice_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !kind_o) |-> (!compare_enable_o && !error_o))
    else $error("notice item carries status fields");

  a_running_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(running_q) == $countones(valid_vec))
    else $error("running timers and queued slots differ");

  a_queue_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head.valid |-> (valid_vec == '0))
    else $error("queue has a hole at the head");

endmodule

[hdl/stq_cell.sv]
`timescale 1ns / 1ps
module stq_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stq_pkg::cell_cmd_t cmd_i,
  input  stq_pkg::slot_t    left_i,
  input  stq_pkg::slot_t    right_i,
  input  logic              hit_i,
  output logic              hit_o,
  output stq_pkg::slot_t    slot_o
);

  stq_pkg::slot_t slot_q, slot_d;
  logic           match;

  // does the command land on this slot
  always_comb begin
    match = 1'b0;
    case (cmd_i.op)
      stq_pkg::CELL_INSERT: match = slot_q.valid &&
                                    stq_pkg::tick_before(cmd_i.expiry, slot_q.expiry);
      stq_pkg::CELL_REMOVE: match = slot_q.valid && (slot_q.id == cmd_i.id);
      stq_pkg::CELL_POP:    match = 1'b1;
      default:              match = 1'b0;
    endcase
  end

  assign hit_o = hit_i | match;

  // shift right on insert, shift left on remove and pop
  always_comb begin
    slot_d = slot_q;
    case (cmd_i.op)
      stq_pkg::CELL_INSERT: begin
        if (hit_i) begin
          slot_d = left_i;
        end else if (match || (!slot_q.valid && left_i.valid)) begin
          slot_d.valid  = 1'b1;
          slot_d.id     = cmd_i.id;
          slot_d.expiry = cmd_i.expiry;
        end
      end
      stq_pkg::CELL_REMOVE, stq_pkg::CELL_POP: begin
        if (hit_o) slot_d = right_i;
      end
      default: slot_d = slot_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule

[tb/sorted_timer_expiry_queue_tb.sv]
`timescale 1ns / 1ps
module sorted_timer_expiry_queue_tb;

  localparam int MaxCycles = 400000;

  typedef struct packed {
    logic                          kind;
    logic [stq_pkg::IdWidth-1:0]   id;
    logic                          en;
    logic [stq_pkg::TickWidth-1:0] val;
    logic                          err;
    logic                          last;
  } note_t;

  typedef struct {
    stq_pkg::func_e                fn;
    logic [stq_pkg::IdWidth-1:0]   id;
    logic [stq_pkg::TickWidth-1:0] exp_tick;
    logic [stq_pkg::TickWidth-1:0] now;
    bit                            has_want;
    note_t                         want;
  } row_t;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_stall_o;
  logic [stq_pkg::FuncWidth-1:0] func_i = '0;
  logic [stq_pkg::IdWidth-1:0] timer_id_i = '0;
  logic [stq_pkg::TickWidth-1:0] expiry_tick_i = '0;
  logic [stq_pkg::TickWidth-1:0] now_tick_i = '0;
  logic out_valid_o;
  logic out_stall_i = 0;
  logic kind_o;
  logic [stq_pkg::IdWidth-1:0] expired_id_o;
  logic compare_enable_o;
  logic [stq_pkg::TickWidth-1:0] compare_value_o;
  logic error_o;
  logic last_o;

  sorted_timer_expiry_queue dut (.*);

  always #5 clk_i = ~clk_i;

  // predicted queue state
  logic [stq_pkg::IdWidth-1:0]   q_order[stq_pkg::NumTimers];
  logic [stq_pkg::TickWidth-1:0] q_expiry[stq_pkg::NumTimers];
  bit                            q_running[stq_pkg::NumTimers];
  int                            q_count;

  note_t pending_notes[$];
  int    send_idle_pct, recv_stall_pct;
  bit    failed = 0;
  int    cycles = 0;

  function automatic bit is_before(logic [stq_pkg::TickWidth-1:0] a,
                                   logic [stq_pkg::TickWidth-1:0] b);
    logic [stq_pkg::TickWidth-1:0] d;
    d = a - b;
    return d[stq_pkg::TickWidth-1];
  endfunction

  function automatic note_t status_note(bit err);
    note_t n;
    n = '{kind: 1'b1, id: '0, en: 1'b0, val: '0, err: err, last: 1'b1};
    if (q_count > 0) begin
      n.en = 1'b1;
      n.val = q_expiry[q_order[0]];
    end
    return n;
  endfunction

  // advance the queue model by one item and push the notes it causes
  function automatic void predict_queue(stq_pkg::func_e fn,
                                        logic [stq_pkg::IdWidth-1:0] id,
                                        logic [stq_pkg::TickWidth-1:0] et,
                                        logic [stq_pkg::TickWidth-1:0] now);
    bit err;
    int pos, j;
    logic [stq_pkg::IdWidth-1:0] hd;
    logic [stq_pkg::TickWidth-1:0] d;
    note_t n;
    err = 0;
    case (fn)
      stq_pkg::FUNC_START: begin
        if (q_running[id] || q_count >= stq_pkg::NumTimers) begin
          err = 1;
        end else begin
          q_expiry[id] = et;
          pos = q_count;
          for (j = 0; j < q_count; j++) begin
            if (is_before(et, q_expiry[q_order[j]])) begin
              pos = j;
              break;
            end
          end
          for (j = q_count; j > pos; j--) q_order[j] = q_order[j-1];
          q_order[pos] = id;
          q_count++;
          q_running[id] = 1;
        end
      end
      stq_pkg::FUNC_STOP: begin
        if (q_running[id]) begin
          pos = -1;
          for (j = 0; j < q_count; j++) if (pos < 0 && q_order[j] == id) pos = j;
          for (j = pos; j + 1 < q_count; j++) q_order[j] = q_order[j+1];
          q_count--;
          q_running[id] = 0;
        end
      end
      stq_pkg::FUNC_CHECK: begin
        while (q_count > 0) begin
          hd = q_order[0];
          d = q_expiry[hd] - now;
          if (d != '0 && !d[stq_pkg::TickWidth-1]) break;
          for (j = 0; j + 1 < q_count; j++) q_order[j] = q_order[j+1];
          q_count--;
          q_running[hd] = 0;
          n = '{kind: 1'b0, id: hd, en: 1'b0, val: '0, err: 1'b0, last: 1'b0};
          pending_notes.push_back(n);
        end
      end
      default: ;
    endcase
    pending_notes.push_back(status_note(err));
  endfunction

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycles) begin
      $display("sorted_timer_expiry_queue test failed");
      $finish;
    end
  end

  // receiver stall and result check
  always @(posedge clk_i) begin
    note_t got, want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{kind_o, expired_id_o, compare_enable_o, compare_value_o, error_o, last_o};
        if (pending_notes.size() == 0) begin
          $display("%0t: unexpected item %p", $time, got);
          failed = 1;
        end else begin
          want = pending_notes.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            failed = 1;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_item(stq_pkg::func_e fn, logic [stq_pkg::IdWidth-1:0] id,
                           logic [stq_pkg::TickWidth-1:0] et,
                           logic [stq_pkg::TickWidth-1:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    func_i <= fn;
    timer_id_i <= id;
    expiry_tick_i <= et;
    now_tick_i <= now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_queue(fn, id, et, now);
  endtask

  task automatic drain_queue();
    in_valid_i <= 0;
    while (pending_notes.size() != 0) @(posedge clk_i);
  endtask

  function automatic row_t mk(stq_pkg::func_e fn, int id, logic [31:0] et,
                              logic [31:0] now, bit hw = 0, bit en = 0,
                              logic [31:0] val = 0, bit err = 0);
    row_t r;
    r.fn = fn; r.id = id[stq_pkg::IdWidth-1:0]; r.exp_tick = et; r.now = now;
    r.has_want = hw;
    r.want = '{kind: 1'b1, id: '0, en: en, val: val, err: err, last: 1'b1};
    return r;
  endfunction

  row_t directed[$];
  stq_pkg::func_e fn;
  logic [31:0] base;
  int i, k, phase;

  initial begin
    for (i = 0; i < stq_pkg::NumTimers; i++) begin
      q_running[i] = 0; q_order[i] = '0; q_expiry[i] = '0;
    end
    q_count = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: empty checks, extremes, errors, wrap, equal expiries, unused code
    directed.push_back(mk(stq_pkg::FUNC_CHECK, 0, 0, 0, 1, 0, 0, 0));
    directed.push_back(mk(stq_pkg::FUNC_STOP, 15, 0, 0, 1, 0, 0, 0));
    directed.push_back(mk(stq_pkg::FUNC_NONE, 15, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 0, 0, 0));
    directed.push_back(mk(stq_pkg::FUNC_START, 0, 32'hFFFFFFFF, 0, 1, 1, 32'hFFFFFFFF, 0));
    directed.push_back(mk(stq_pkg::FUNC_START, 0, 32'h5, 0, 1, 1, 32'hFFFFFFFF, 1));
    directed.push_back(mk(stq_pkg::FUNC_START, 15, 32'h0000_0001, 0));
    directed.push_back(mk(stq_pkg::FUNC_START, 7, 32'h0000_0001, 0));
    directed.push_back(mk(stq_pkg::FUNC_START, 8, 32'h8000_0000, 0));
    directed.push_back(mk(stq_pkg::FUNC_START, 9, 32'h7FFF_FFFF, 0));
    directed.push_back(mk(stq_pkg::FUNC_STOP, 3, 0, 0));
    directed.push_back(mk(stq_pkg::FUNC_STOP, 7, 0, 0));
    directed.push_back(mk(stq_pkg::FUNC_CHECK, 0, 0, 32'h0000_0001));
    directed.push_back(mk(stq_pkg::FUNC_CHECK, 0, 0, 32'hFFFF_FFFF));
    directed.push_back(mk(stq_pkg::FUNC_CHECK, 0, 0, 32'h8000_0000));
    directed.push_back(mk(stq_pkg::FUNC_CHECK, 0, 0, 32'h0000_0000));
    for (i = 0; i < stq_pkg::NumTimers; i++)
      directed.push_back(mk(stq_pkg::FUNC_START, i, 32'h100 + (i % 3), 0));
    directed.push_back(mk(stq_pkg::FUNC_CHECK, 0, 0, 32'h200));
    foreach (directed[j]) begin
      if (directed[j].has_want) begin
        drain_queue();
        send_item(directed[j].fn, directed[j].id, directed[j].exp_tick, directed[j].now);
        pending_notes[pending_notes.size()-1] = directed[j].want;
      end else begin
        send_item(directed[j].fn, directed[j].id, directed[j].exp_tick, directed[j].now);
      end
    end
    drain_queue();

    // random: mostly starts near a moving base, checks that sweep past it
    base = $urandom;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      for (k = 0; k < 17; k++) begin
        i = $urandom_range(99);
        if (i < 50) fn = stq_pkg::FUNC_START;
        else if (i < 68) fn = stq_pkg::FUNC_STOP;
        else if (i < 95) fn = stq_pkg::FUNC_CHECK;
        else fn = stq_pkg::FUNC_NONE;
        if ($urandom_range(9) == 0)
          send_item(fn, stq_pkg::IdWidth'($urandom), $urandom, $urandom);
        else
          send_item(fn, stq_pkg::IdWidth'($urandom), base + $urandom_range(400) - 100,
                    base + $urandom_range(300) - 100);
        if (fn == stq_pkg::FUNC_CHECK) base = base + $urandom_range(120);
      end
      // hold off until every result is back
      drain_queue();
    end
    recv_stall_pct = 0;
    repeat (30) @(posedge clk_i);
    if (!failed && pending_notes.size() == 0) begin
      $display("sorted_timer_expiry_queue test passed");
    end else begin
      $display("sorted_timer_expiry_queue test failed");
    end
    $finish;
  end

endmodule
